// ===== src/sawt_pkg.sv =====
// Shared types, widths and codes for the sorted address watch table.
package sawt_pkg;

    // Table geometry.
    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths.
    localparam int ADDR_W = 32;
    localparam int LEN_W = 31;
    localparam int POS_W = 8;
    localparam int OP_W = 2;
    localparam int STAT_W = 2;
    localparam int RANK_W = 6;
    localparam int RNK_CMP_W = 9;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // Request beat.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [POS_W-1:0]  position;
    } req_t;

    // Response beat.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [RANK_W-1:0] rank;
        logic [RANK_W-1:0] entry_count;
    } rsp_t;

    // Control broadcast to every cell.
    typedef struct packed {
        logic              ins_en;
        logic              del_en;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] lo;
        logic [POS_W-1:0]  position;
    } cell_ctl_t;

endpackage

// ===== src/sawt_cell.sv =====
// One slot of the sorted table: holds an address and shifts with its neighbors.
module sawt_cell (
    input  logic                       clk,
    input  logic                       valid,
    input  logic [sawt_pkg::IDX_W-1:0] idx,
    input  sawt_pkg::cell_ctl_t        ctl,
    input  logic [sawt_pkg::ADDR_W-1:0] prev_val,
    input  logic                       prev_le,
    input  logic                       prev_lt_lo,
    input  logic [sawt_pkg::ADDR_W-1:0] next_val,
    output logic [sawt_pkg::ADDR_W-1:0] val,
    output logic                       le,
    output logic                       lt_lo,
    output logic                       hit
);

    logic [sawt_pkg::ADDR_W-1:0] val_reg;
    logic [sawt_pkg::ADDR_W-1:0] val_next;
    logic                        lt_addr;
    logic                        del_here;

    // Local comparisons against the broadcast operands.
    assign le      = valid && (val_reg <= ctl.addr);
    assign lt_lo   = valid && (val_reg < ctl.lo);
    assign lt_addr = val_reg < ctl.addr;

    // The first valid cell at or above the lower bound is the only candidate.
    assign hit = valid && !lt_lo && lt_addr && prev_lt_lo;

    // This cell sits at or past the deleted rank.
    assign del_here = (sawt_pkg::RNK_CMP_W'(idx) + sawt_pkg::RNK_CMP_W'(1))
                      >= sawt_pkg::RNK_CMP_W'(ctl.position);

    // Insert shifts up from the slot, delete shifts down from the rank.
    always_comb
    begin
        val_next = val_reg;
        if (ctl.ins_en && !le)
        begin
            val_next = prev_le ? ctl.addr : prev_val;
        end
        else if (ctl.del_en && del_here)
        begin
            val_next = next_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ===== src/sorted_address_watch_table_top.sv =====
// Top level of the sorted address watch table: control, cell chain and response register.
// The response beat is registered and appears in the cycle after its request beat is taken.
// Throughput: one beat per cycle while responses are taken; a request is taken whenever the
// response register is empty or being emptied in the same cycle.
// Reset clears the entry count and the response valid; cell contents are undefined until
// written and are never read beyond the entry count.
module sorted_address_watch_table_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  sawt_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output sawt_pkg::rsp_t   rsp
);

    logic [sawt_pkg::CNT_W-1:0] count_reg;
    logic [sawt_pkg::CNT_W-1:0] count_next;
    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    sawt_pkg::rsp_t             rsp_reg;
    sawt_pkg::rsp_t             rsp_next;

    logic                       accept;
    logic                       full;
    logic                       pos_ok;
    sawt_pkg::cell_ctl_t        ctl;

    logic [sawt_pkg::DEPTH-1:0]  cell_valid;
    logic [sawt_pkg::ADDR_W-1:0] cell_val [sawt_pkg::DEPTH];
    logic [sawt_pkg::DEPTH-1:0]  cell_le;
    logic [sawt_pkg::DEPTH-1:0]  cell_lt_lo;
    logic [sawt_pkg::DEPTH-1:0]  cell_hit;

    logic [sawt_pkg::IDX_W-1:0]  hit_idx;
    logic                        hit_any;
    logic [sawt_pkg::CNT_W-1:0]  hit_rank;

    // Handshake: the response register parts the two sides.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    // Operation qualification.
    assign full   = count_reg == sawt_pkg::CNT_W'(sawt_pkg::DEPTH);
    assign pos_ok = (req.position != '0)
                    && (sawt_pkg::RNK_CMP_W'(req.position) <= sawt_pkg::RNK_CMP_W'(count_reg));

    // Broadcast control to the cells.
    always_comb
    begin
        ctl.ins_en   = accept && (req.op == sawt_pkg::OP_INSERT) && !full;
        ctl.del_en   = accept && (req.op == sawt_pkg::OP_DELETE) && pos_ok;
        ctl.addr     = req.addr;
        ctl.lo       = req.addr - sawt_pkg::ADDR_W'(req.len);
        ctl.position = req.position;
    end

    // Cell chain; the ends see fixed neighbor values.
    genvar k;
    generate
        for (k = 0; k < sawt_pkg::DEPTH; k++)
        begin : g_cell
            logic [sawt_pkg::ADDR_W-1:0] prev_val;
            logic                        prev_le;
            logic                        prev_lt_lo;
            logic [sawt_pkg::ADDR_W-1:0] next_val;

            assign cell_valid[k] = sawt_pkg::CNT_W'(k) < count_reg;

            if (k == 0)
            begin : g_first
                assign prev_val   = '0;
                assign prev_le    = 1'b1;
                assign prev_lt_lo = 1'b1;
            end
            else
            begin : g_mid
                assign prev_val   = cell_val[k-1];
                assign prev_le    = cell_le[k-1];
                assign prev_lt_lo = cell_lt_lo[k-1];
            end

            if (k == sawt_pkg::DEPTH - 1)
            begin : g_last
                assign next_val = '0;
            end
            else
            begin : g_inner
                assign next_val = cell_val[k+1];
            end

            sawt_cell u_cell (
                .clk        (clk),
                .valid      (cell_valid[k]),
                .idx        (sawt_pkg::IDX_W'(k)),
                .ctl        (ctl),
                .prev_val   (prev_val),
                .prev_le    (prev_le),
                .prev_lt_lo (prev_lt_lo),
                .next_val   (next_val),
                .val        (cell_val[k]),
                .le         (cell_le[k]),
                .lt_lo      (cell_lt_lo[k]),
                .hit        (cell_hit[k])
            );
        end
    endgenerate

    // One-hot hit vector to rank.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < sawt_pkg::DEPTH; i++)
        begin
            if (cell_hit[i])
            begin
                hit_idx = hit_idx | sawt_pkg::IDX_W'(i);
            end
        end
    end

    assign hit_any  = |cell_hit;
    assign hit_rank = sawt_pkg::CNT_W'(hit_idx) + sawt_pkg::CNT_W'(1);

    // Next entry count.
    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins_en)
        begin
            count_next = count_reg + sawt_pkg::CNT_W'(1);
        end
        else if (ctl.del_en)
        begin
            count_next = count_reg - sawt_pkg::CNT_W'(1);
        end
    end

    // Response beat formation.
    always_comb
    begin
        rsp_next.status      = sawt_pkg::ST_OK;
        rsp_next.rank        = '0;
        rsp_next.entry_count = sawt_pkg::RANK_W'(count_next);
        case (req.op)
            sawt_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = sawt_pkg::ST_FULL;
                end
            end
            sawt_pkg::OP_DELETE:
            begin
                if (!pos_ok)
                begin
                    rsp_next.status = sawt_pkg::ST_NONE;
                end
            end
            sawt_pkg::OP_SEARCH:
            begin
                if (hit_any)
                begin
                    rsp_next.rank = sawt_pkg::RANK_W'(hit_rank);
                end
            end
            default:
            begin
                rsp_next.status = sawt_pkg::ST_NONE;
            end
        endcase
    end

    assign rsp_valid_next = accept || (rsp_valid_reg && !rsp_ready);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== tb/sawt_watch_checker.sv =====
// Checker that mirrors the sorted address watch table and compares every response beat.
`timescale 1ns / 1ps

module sawt_watch_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_ready,
    input  sawt_pkg::req_t   req,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  sawt_pkg::rsp_t   rsp,
    output int               errors,
    output int               pending,
    output int               search_hits,
    output int               full_rejects
);

    import sawt_pkg::*;

    // Mirror of the table contents and its fill level.
    logic [ADDR_W-1:0] watch_cells [DEPTH];
    int                watch_count;

    // Responses still owed by the block, oldest first.
    rsp_t              owed_rsp [$];
    int                shown;

    // Applies one request to the mirror and returns the response it must produce.
    function automatic rsp_t apply_watch_op(input req_t r);
        rsp_t              e;
        int                slot;
        int                k;
        logic [ADDR_W-1:0] lo;
        e = '0;
        e.status = ST_OK;
        case (r.op)
            OP_INSERT:
            begin
                if (watch_count >= DEPTH)
                begin
                    e.status = ST_FULL;
                end
                else
                begin
                    // The new address goes after every equal one already stored.
                    slot = 0;
                    while (slot < watch_count && watch_cells[slot] <= r.addr)
                        slot++;
                    for (k = watch_count; k > slot; k--)
                        watch_cells[k] = watch_cells[k-1];
                    watch_cells[slot] = r.addr;
                    watch_count++;
                end
            end
            OP_DELETE:
            begin
                if (r.position == 0 || r.position > watch_count)
                begin
                    e.status = ST_NONE;
                end
                else
                begin
                    for (k = r.position - 1; k + 1 < watch_count; k++)
                        watch_cells[k] = watch_cells[k+1];
                    watch_count--;
                end
            end
            OP_SEARCH:
            begin
                // The lower bound wraps; a wrapped bound leaves the window empty.
                lo = r.addr - {1'b0, r.len};
                for (k = 0; k < watch_count; k++)
                begin
                    if (watch_cells[k] < r.addr && watch_cells[k] >= lo)
                    begin
                        e.rank = RANK_W'(k + 1);
                        break;
                    end
                end
            end
            default:
            begin
                e.status = ST_NONE;
            end
        endcase
        e.entry_count = RANK_W'(watch_count);
        return e;
    endfunction

    // Compare the response first, since it always belongs to an earlier request.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            owed_rsp.delete();
            watch_count = 0;
            pending = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (owed_rsp.size() == 0)
                begin
                    errors++;
                    if (shown < 10)
                        $display("Unexpected response beat: status %0d rank %0d count %0d",
                                 rsp.status, rsp.rank, rsp.entry_count);
                    shown++;
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    if (rsp.status !== want.status || rsp.rank !== want.rank ||
                        rsp.entry_count !== want.entry_count)
                    begin
                        errors++;
                        if (shown < 10)
                            $display({"Mismatch: expected status %0d rank %0d count %0d, ",
                                      "got status %0d rank %0d count %0d"},
                                     want.status, want.rank, want.entry_count,
                                     rsp.status, rsp.rank, rsp.entry_count);
                        shown++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                want = apply_watch_op(req);
                if (want.status == ST_FULL)
                    full_rejects++;
                if (want.rank != 0)
                    search_hits++;
                owed_rsp.push_back(want);
            end
            pending = owed_rsp.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the sorted address watch table: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    import sawt_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int IDLE_PCT = 16;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    req_t              req = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    rsp_t              rsp;

    logic              req_taken = 1'b0;
    logic              calm = 1'b0;
    int                errors;
    int                pending;
    int                search_hits;
    int                full_rejects;
    int                cycles = 0;
    int                op_sent [4];
    logic [ADDR_W-1:0] addr_pool [$];

    sorted_address_watch_table_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    sawt_watch_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .errors       (errors),
        .pending      (pending),
        .search_hits  (search_hits),
        .full_rejects (full_rejects)
    );

    // 12 ns clock period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit, far above the slowest correct run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Note each accepted request beat so the driver can move on at the next falling edge.
    always @(posedge clk)
        req_taken <= req_valid && req_ready;

    // The response side stalls at random, except during the calm stretch.
    always @(negedge clk)
        rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    function automatic req_t make_req(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                      input logic [LEN_W-1:0] len,
                                      input logic [POS_W-1:0] position);
        req_t r;
        r.op = op;
        r.addr = addr;
        r.len = len;
        r.position = position;
        return r;
    endfunction

    // Random request; the phase steers the mix toward filling, draining or searching.
    function automatic req_t random_req(input int phase);
        req_t        r;
        int unsigned roll;
        int unsigned ins_pct;
        int unsigned del_pct;
        int unsigned srch_pct;
        r.addr = $urandom;
        r.len = LEN_W'($urandom);
        r.position = POS_W'($urandom);
        case (phase)
            0:       begin ins_pct = 70; del_pct = 10; srch_pct = 17; end
            1:       begin ins_pct = 35; del_pct = 30; srch_pct = 30; end
            2:       begin ins_pct = 15; del_pct = 60; srch_pct = 22; end
            default: begin ins_pct = 25; del_pct = 25; srch_pct = 48; end
        endcase
        roll = $urandom_range(99);
        if (roll < ins_pct)
        begin
            r.op = OP_INSERT;
            roll = $urandom_range(99);
            // Reuse stored addresses now and then so that equal entries pile up.
            if (roll < 40 && addr_pool.size() != 0)
                r.addr = addr_pool[$urandom_range(addr_pool.size() - 1)] + $urandom_range(3);
            else if (roll < 55)
                r.addr = $urandom_range(255);
            else if (roll < 60)
                r.addr = 32'hFFFF_FF00 + $urandom_range(255);
        end
        else if (roll < ins_pct + del_pct)
        begin
            r.op = OP_DELETE;
            roll = $urandom_range(99);
            if (roll < 80)
                r.position = POS_W'($urandom_range(DEPTH + 1, 1));
            else if (roll < 90)
                r.position = '0;
        end
        else if (roll < ins_pct + del_pct + srch_pct)
        begin
            r.op = OP_SEARCH;
            roll = $urandom_range(99);
            // Most searches sit just above a stored address with a short window.
            if (roll < 70 && addr_pool.size() != 0)
            begin
                r.addr = addr_pool[$urandom_range(addr_pool.size() - 1)] + $urandom_range(40);
                r.len = LEN_W'($urandom_range(80));
            end
            else if (roll < 85)
            begin
                r.len = LEN_W'($urandom_range(4096));
            end
        end
        else
        begin
            r.op = OP_UNUSED;
        end
        return r;
    endfunction

    // Drive one request beat and return at the falling edge after it was taken.
    task automatic issue(input req_t r);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(negedge clk);
        while (!req_taken)
            @(negedge clk);
        op_sent[r.op]++;
        if (r.op == OP_INSERT)
        begin
            addr_pool.push_back(r.addr);
            if (addr_pool.size() > 64)
                void'(addr_pool.pop_front());
        end
    endtask

    // Hold off new requests until every owed response has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int i;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table: search miss and deletes that find nothing.
        issue(make_req(OP_SEARCH, 32'h0000_0100, 31'h10, 8'd0));
        issue(make_req(OP_DELETE, 32'h0, 31'h0, 8'd0));
        issue(make_req(OP_DELETE, 32'h0, 31'h0, 8'd1));

        // Extreme addresses and a duplicate.
        issue(make_req(OP_INSERT, 32'h0000_1000, 31'h0, 8'd0));
        issue(make_req(OP_INSERT, 32'hFFFF_FFFF, 31'h0, 8'd0));
        issue(make_req(OP_INSERT, 32'h0000_0000, 31'h0, 8'd0));
        issue(make_req(OP_INSERT, 32'h0000_1000, 31'h7FFF_FFFF, 8'hFF));
        issue(make_req(OP_INSERT, 32'h8000_0000, 31'h0, 8'd0));

        // Widest window, a hit on the first of two equal entries, an empty window,
        // a wrapped lower bound, and a window that reaches address zero.
        issue(make_req(OP_SEARCH, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'd0));
        issue(make_req(OP_SEARCH, 32'h0000_1001, 31'h1, 8'd0));
        issue(make_req(OP_SEARCH, 32'h0000_1000, 31'h0, 8'd0));
        issue(make_req(OP_SEARCH, 32'h0000_0010, 31'h100, 8'd0));
        issue(make_req(OP_SEARCH, 32'h0000_0001, 31'h1, 8'd0));

        // Unused code and deletes out of range, then valid deletes at both ends.
        issue(make_req(OP_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF));
        issue(make_req(OP_DELETE, 32'h0, 31'h0, 8'd255));
        issue(make_req(OP_DELETE, 32'h0, 31'h0, 8'd6));
        issue(make_req(OP_DELETE, 32'h0, 31'h0, 8'd5));
        issue(make_req(OP_DELETE, 32'h0, 31'h0, 8'd1));
        issue(make_req(OP_DELETE, 32'h0, 31'h0, 8'd2));
        issue(make_req(OP_SEARCH, 32'h8000_0001, 31'h7FFF_FFFF, 8'd0));
        wait_drained();

        // Random part: alternating fill, mixed, drain and search-heavy phases.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 400 || i == 1200)
                wait_drained();
            if (i == 600)
                calm <= 1'b1;
            if (i == 900)
                calm <= 1'b0;
            issue(random_req((i / 200) % 4));
        end

        wait_drained();
        repeat (4) @(negedge clk);
        $display("Sent %0d inserts, %0d deletes, %0d searches and %0d unused-code beats.",
                 op_sent[OP_INSERT], op_sent[OP_DELETE], op_sent[OP_SEARCH],
                 op_sent[OP_UNUSED]);
        $display("Searches hit %0d times; %0d inserts were refused by a full table.",
                 search_hits, full_rejects);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
